[src/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lcdfb_pkg.sv]
// Package for the paged LCD framebuffer packetizer: operation and register
// codes, packet layout constants and header byte functions. No dependencies.
package lcdfb_pkg;

  localparam logic [1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [1:0] OP_CLEAR     = 2'd1;
  localparam logic [1:0] OP_REFRESH   = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPSIDE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE0  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE1  = 3'd5;

  localparam logic [8:0] WIDTH_RESET  = 9'd256;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;
  localparam logic [7:0] CODE0_RESET  = 8'd149;
  localparam logic [7:0] CODE1_RESET  = 8'd150;

  localparam logic [5:0] PKT0_LAST_POS  = 6'd43;
  localparam logic [5:0] PKT1_LAST_POS  = 6'd37;
  localparam logic [5:0] PKT0_COL_FIRST = 6'd12;
  localparam logic [5:0] PKT1_COL_FIRST = 6'd5;
  localparam logic [5:0] COLS_PER_PKT   = 6'd32;

  localparam logic [7:0] PAGE_CMD       = 8'hB8;
  localparam logic [7:0] COL_CMD        = 8'h40;
  localparam logic [7:0] CMD_FLAG       = 8'h02;
  localparam logic [7:0] DATA_CHIP_FLAG = 8'h01;
  localparam logic [7:0] XFER_LEN       = 8'd32;
  localparam logic [7:0] BYTE_ONES      = 8'hFF;

  localparam logic [1:0] LAST_CHIP = 2'd3;
  localparam logic [2:0] LAST_PAGE = 3'd7;

  function automatic logic is_col_byte(input logic pkt, input logic [5:0] pos);
    logic hit;
    if (pkt) begin
      hit = (pos >= PKT1_COL_FIRST) && (pos < PKT1_COL_FIRST + COLS_PER_PKT);
    end else begin
      hit = (pos >= PKT0_COL_FIRST) && (pos < PKT0_COL_FIRST + COLS_PER_PKT);
    end
    return hit;
  endfunction

  // Column offset within the 64-column section, 0..63.
  function automatic logic [5:0] col_offset(input logic pkt, input logic [5:0] pos);
    logic [5:0] rel;
    rel = pkt ? (pos - PKT1_COL_FIRST) : (pos - PKT0_COL_FIRST);
    return {pkt, rel[4:0]};
  endfunction

  function automatic logic [7:0] hdr_byte(input logic pkt, input logic [5:0] pos,
                                          input logic [1:0] chip, input logic [2:0] page,
                                          input logic [7:0] code0, input logic [7:0] code1);
    logic [7:0] b;
    b = 8'h00;
    if (!pkt) begin
      unique case (pos)
        6'd0:    b = code0;
        6'd1:    b = {4'b0000, chip, 2'b00};
        6'd2:    b = CMD_FLAG;
        6'd5:    b = PAGE_CMD | {5'b00000, page};
        6'd8:    b = COL_CMD;
        6'd11:   b = XFER_LEN;
        default: b = 8'h00;
      endcase
    end else begin
      unique case (pos)
        6'd0:    b = code1;
        6'd1:    b = {4'b0000, chip, 2'b00} | DATA_CHIP_FLAG;
        6'd4:    b = XFER_LEN;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

[src/lcdfb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lcdfb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/paged_lcd_framebuffer_packetizer.sv]
// Top level of the paged LCD framebuffer packetizer: sequencer, store and
// packet assembly. Depends on lcdfb_pkg, lcdfb_ram and assert_macros.svh.
//
// Usage: items enter on the in_ valid/ready channel and carry an operation.
// A set-pixel item inside the active area does a read-modify-write of one
// store byte. A clear item zeroes all DISPLAY_COLUMNS * pages store bytes
// (2048 by default), one byte per cycle.
// A refresh item, when the buffer is dirty or forced, emits eleven 64-bit
// words on the out_ valid/ready channel: six for the command-plus-data
// packet and five for the data-only packet, out_last on the eleventh.
// Each word is assembled one byte per cycle through the single store read
// port. The output word sits in a register, so the next item is accepted
// while the final word still waits; when the receiver stalls, assembly
// pauses with the next word held. Reset runs a clearing pass over the
// store of the same length as a clear item, during which in_ready stays
// low; configuration writes are taken at any time.
`include "assert_macros.svh"

module paged_lcd_framebuffer_packetizer #(
  parameter int DISPLAY_COLUMNS = 256,
  parameter int DISPLAY_ROWS    = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_operation,
  input  logic [7:0]                          in_pixel_x,
  input  logic [5:0]                          in_pixel_y,
  input  logic                                in_pixel_white,
  input  logic [1:0]                          in_chip,
  input  logic [2:0]                          in_page,
  input  logic                                in_force_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         out_data_word,
  output logic [3:0]                          out_valid_bytes,
  output logic                                out_which_packet,
  output logic                                out_packet_end,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [lcdfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lcdfb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PAGE_COUNT  = (DISPLAY_ROWS + 7) / 8;
  localparam int STORE_DEPTH = DISPLAY_COLUMNS * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int X_W         = $clog2(DISPLAY_COLUMNS);
  localparam int CALC_W      = $clog2(8 * DISPLAY_COLUMNS + 256) + 1;

  localparam logic [CALC_W-1:0] COLS_C    = CALC_W'(DISPLAY_COLUMNS);
  localparam logic [6:0]        ROWS_C    = 7'(DISPLAY_ROWS);
  localparam logic [3:0]        PAGES_C   = 4'(PAGE_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PX_RD,
    ST_PX_WR,
    ST_ASM,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [8:0]        width_r, width_nxt;
  logic [6:0]        height_r, height_nxt;
  logic              upside_r, upside_nxt;
  logic              invert_r, invert_nxt;
  logic [7:0]        code0_r, code0_nxt;
  logic [7:0]        code1_r, code1_nxt;
  logic              dirty_r, dirty_nxt;

  logic [X_W-1:0]    px_x_r, px_x_nxt;
  logic [5:0]        px_y_r, px_y_nxt;
  logic              px_white_r, px_white_nxt;
  logic [ADDR_W-1:0] px_addr_r, px_addr_nxt;

  logic [1:0]        chip_r, chip_nxt;
  logic [2:0]        page_r, page_nxt;
  logic              pkt_r, pkt_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [2:0]        lane_r, lane_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic [3:0]        nbytes_r, nbytes_nxt;
  logic              pend_end_r, pend_end_nxt;

  logic              b_vld_r, b_vld_nxt;
  logic              b_col_r, b_col_nxt;
  logic              b_ok_r, b_ok_nxt;
  logic [7:0]        b_const_r, b_const_nxt;
  logic [2:0]        b_lane_r, b_lane_nxt;
  logic [63:0]       word_r, word_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic [3:0]        out_nbytes_r, out_nbytes_nxt;
  logic              out_which_r, out_which_nxt;
  logic              out_pend_r, out_pend_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic [CALC_W-1:0] eff_w, x_ext, mir_x;
  logic [6:0]        eff_h, y_ext, mir_y;
  logic              px_hit;
  logic [CALC_W-1:0] pix_calc;
  logic [7:0]        px_mask, px_wdata;
  logic [7:0]        col_num;
  logic              col_ok;
  logic [CALC_W-1:0] col_calc;
  logic [5:0]        last_pos;
  logic              word_end;
  logic [7:0]        b_byte;

  lcdfb_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pixel range check and mirroring on the incoming item.
  always_comb begin
    eff_w  = ((width_r == 9'd0) || (CALC_W'(width_r) > COLS_C)) ? COLS_C : CALC_W'(width_r);
    eff_h  = ((height_r == 7'd0) || (height_r > ROWS_C)) ? ROWS_C : height_r;
    x_ext  = CALC_W'(in_pixel_x);
    y_ext  = {1'b0, in_pixel_y};
    px_hit = (x_ext < eff_w) && (y_ext < eff_h);
    mir_x  = eff_w - CALC_W'(1) - x_ext;
    mir_y  = eff_h - 7'd1 - y_ext;
  end

  assign pix_calc = CALC_W'(px_y_r[5:3]) * COLS_C + CALC_W'(px_x_r);
  assign px_mask  = 8'd1 << px_y_r[2:0];
  assign px_wdata = px_white_r ? (ram_rdata | px_mask) : (ram_rdata & ~px_mask);

  assign col_num  = {chip_r, lcdfb_pkg::col_offset(pkt_r, pos_r)};
  assign col_ok   = ({1'b0, page_r} < PAGES_C) && (CALC_W'(col_num) < COLS_C);
  assign col_calc = CALC_W'(page_r) * COLS_C + CALC_W'(col_num);
  assign last_pos = pkt_r ? lcdfb_pkg::PKT1_LAST_POS : lcdfb_pkg::PKT0_LAST_POS;
  assign word_end = (lane_r == 3'd7) || (pos_r == last_pos);

  assign b_byte = b_col_r
                ? ((b_ok_r ? ram_rdata : 8'h00) ^ (invert_r ? lcdfb_pkg::BYTE_ONES : 8'h00))
                : b_const_r;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    upside_nxt     = upside_r;
    invert_nxt     = invert_r;
    code0_nxt      = code0_r;
    code1_nxt      = code1_r;
    dirty_nxt      = dirty_r;
    px_x_nxt       = px_x_r;
    px_y_nxt       = px_y_r;
    px_white_nxt   = px_white_r;
    px_addr_nxt    = px_addr_r;
    chip_nxt       = chip_r;
    page_nxt       = page_r;
    pkt_nxt        = pkt_r;
    pos_nxt        = pos_r;
    lane_nxt       = lane_r;
    iss_done_nxt   = iss_done_r;
    nbytes_nxt     = nbytes_r;
    pend_end_nxt   = pend_end_r;
    b_vld_nxt      = 1'b0;
    b_col_nxt      = b_col_r;
    b_ok_nxt       = b_ok_r;
    b_const_nxt    = b_const_r;
    b_lane_nxt     = b_lane_r;
    word_nxt       = word_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_nbytes_nxt = out_nbytes_r;
    out_which_nxt  = out_which_r;
    out_pend_nxt   = out_pend_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = px_addr_r;
    ram_wdata      = px_wdata;
    ram_raddr      = col_calc[ADDR_W-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 8'h00;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            lcdfb_pkg::OP_SET_PIXEL: begin
              if (px_hit) begin
                px_x_nxt     = X_W'(upside_r ? mir_x : x_ext);
                px_y_nxt     = 6'(upside_r ? mir_y : y_ext);
                px_white_nxt = in_pixel_white;
                state_nxt    = ST_PX_RD;
              end
            end
            lcdfb_pkg::OP_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            lcdfb_pkg::OP_REFRESH: begin
              if (dirty_r || in_force_req) begin
                chip_nxt     = in_chip;
                page_nxt     = in_page;
                pkt_nxt      = 1'b0;
                pos_nxt      = 6'd0;
                lane_nxt     = 3'd0;
                iss_done_nxt = 1'b0;
                word_nxt     = '0;
                state_nxt    = ST_ASM;
                if ((in_chip == lcdfb_pkg::LAST_CHIP) && (in_page == lcdfb_pkg::LAST_PAGE)) begin
                  dirty_nxt = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_PX_RD: begin
        ram_raddr   = pix_calc[ADDR_W-1:0];
        px_addr_nxt = pix_calc[ADDR_W-1:0];
        state_nxt   = ST_PX_WR;
      end
      ST_PX_WR: begin
        ram_we    = 1'b1;
        dirty_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_ASM: begin
        if (!iss_done_r) begin
          b_vld_nxt   = 1'b1;
          b_col_nxt   = lcdfb_pkg::is_col_byte(pkt_r, pos_r);
          b_ok_nxt    = col_ok;
          b_const_nxt = lcdfb_pkg::hdr_byte(pkt_r, pos_r, chip_r, page_r, code0_r, code1_r);
          b_lane_nxt  = lane_r;
          if (word_end) begin
            iss_done_nxt = 1'b1;
            nbytes_nxt   = 4'(lane_r) + 4'd1;
            pend_end_nxt = (pos_r == last_pos);
          end else begin
            pos_nxt  = pos_r + 6'd1;
            lane_nxt = lane_r + 3'd1;
          end
        end
        if (b_vld_r) begin
          word_nxt[8*b_lane_r +: 8] = b_byte;
        end
        if (iss_done_r && !b_vld_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = word_r;
          out_nbytes_nxt = nbytes_r;
          out_which_nxt  = pkt_r;
          out_pend_nxt   = pend_end_r;
          out_last_nxt   = pend_end_r && pkt_r;
          word_nxt       = '0;
          lane_nxt       = 3'd0;
          iss_done_nxt   = 1'b0;
          if (pend_end_r && pkt_r) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_ASM;
            if (pend_end_r) begin
              pkt_nxt = 1'b1;
              pos_nxt = 6'd0;
            end else begin
              pos_nxt = pos_r + 6'd1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        lcdfb_pkg::CFG_WIDTH:  width_nxt  = cfg_wdata;
        lcdfb_pkg::CFG_HEIGHT: height_nxt = cfg_wdata[6:0];
        lcdfb_pkg::CFG_UPSIDE: begin
          upside_nxt = cfg_wdata[0];
          if (cfg_wdata[0] != upside_r) begin
            dirty_nxt = 1'b1;
          end
        end
        lcdfb_pkg::CFG_INVERT: begin
          invert_nxt = cfg_wdata[0];
          if (cfg_wdata[0] != invert_r) begin
            dirty_nxt = 1'b1;
          end
        end
        lcdfb_pkg::CFG_CODE0:  code0_nxt  = cfg_wdata[7:0];
        lcdfb_pkg::CFG_CODE1:  code1_nxt  = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    px_x_r       <= px_x_nxt;
    px_y_r       <= px_y_nxt;
    px_white_r   <= px_white_nxt;
    px_addr_r    <= px_addr_nxt;
    chip_r       <= chip_nxt;
    page_r       <= page_nxt;
    pkt_r        <= pkt_nxt;
    pos_r        <= pos_nxt;
    lane_r       <= lane_nxt;
    nbytes_r     <= nbytes_nxt;
    pend_end_r   <= pend_end_nxt;
    b_col_r      <= b_col_nxt;
    b_ok_r       <= b_ok_nxt;
    b_const_r    <= b_const_nxt;
    b_lane_r     <= b_lane_nxt;
    word_r       <= word_nxt;
    out_data_r   <= out_data_nxt;
    out_nbytes_r <= out_nbytes_nxt;
    out_which_r  <= out_which_nxt;
    out_pend_r   <= out_pend_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      width_r     <= lcdfb_pkg::WIDTH_RESET;
      height_r    <= lcdfb_pkg::HEIGHT_RESET;
      upside_r    <= 1'b0;
      invert_r    <= 1'b0;
      code0_r     <= lcdfb_pkg::CODE0_RESET;
      code1_r     <= lcdfb_pkg::CODE1_RESET;
      dirty_r     <= 1'b1;
      iss_done_r  <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      upside_r    <= upside_nxt;
      invert_r    <= invert_nxt;
      code0_r     <= code0_nxt;
      code1_r     <= code1_nxt;
      dirty_r     <= dirty_nxt;
      iss_done_r  <= iss_done_nxt;
      b_vld_r     <= b_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_data_word    = out_data_r;
  assign out_valid_bytes  = out_nbytes_r;
  assign out_which_packet = out_which_r;
  assign out_packet_end   = out_pend_r;
  assign out_last         = out_last_r;

  `AST_IMPLIES(a_nbytes_range, out_valid, (out_valid_bytes != 4'd0) && (out_valid_bytes <= 4'd8), "valid_bytes out of range")
  `AST_IMPLIES(a_last_on_data_pkt, out_valid && out_last, out_packet_end && out_which_packet, "last word not at end of data packet")
  `AST_IMPLIES(a_byte_stage_in_asm, b_vld_r, state_r == ST_ASM, "byte stage busy outside assembly")
  `AST_NEXT(a_word_to_emit, (state_r == ST_ASM) && iss_done_r && !b_vld_r, state_r == ST_EMIT, "finished word not handed to emit")

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for paged_lcd_framebuffer_packetizer: a tracker class predicts
// the framebuffer, the dirty flag and the refresh report words, and checks every output word.
// Depends on lcdfb_pkg and the block's RTL only.

module tb;

  localparam int DISP_COLS     = 256;
  localparam int DISP_ROWS     = 64;
  localparam int PAGES         = (DISP_ROWS + 7) / 8;
  localparam int STORE_BYTES   = DISP_COLS * PAGES;
  localparam int SETTLE_CYCLES = 2200;
  localparam int REPORT_LIMIT  = 10;
  localparam int ITEMS_PER_PHASE = 80;
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] pixel_x;
    logic [5:0] pixel_y;
    logic       pixel_white;
    logic [1:0] chip;
    logic [2:0] page;
    logic       force_req;
  } lcd_item_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        which_packet;
    logic        packet_end;
    logic        last;
  } report_word_t;

  typedef logic [7:0] packet_bytes_t [44];

  class framebuffer_tracker;
    logic [7:0]   frame [STORE_BYTES];
    bit           dirty;
    logic [8:0]   width_reg;
    logic [6:0]   height_reg;
    bit           upside;
    bit           inv;
    logic [7:0]   code0;
    logic [7:0]   code1;
    report_word_t expected_words[$];
    int           failures;

    function new();
      foreach (frame[i]) frame[i] = '0;
      dirty      = 1'b1;
      width_reg  = lcdfb_pkg::WIDTH_RESET;
      height_reg = lcdfb_pkg::HEIGHT_RESET;
      upside     = 1'b0;
      inv        = 1'b0;
      code0      = lcdfb_pkg::CODE0_RESET;
      code1      = lcdfb_pkg::CODE1_RESET;
      failures   = 0;
    endfunction

    function int active_width();
      return (width_reg == 0 || width_reg > DISP_COLS) ? DISP_COLS : int'(width_reg);
    endfunction

    function int active_height();
      return (height_reg == 0 || height_reg > DISP_ROWS) ? DISP_ROWS : int'(height_reg);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [lcdfb_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lcdfb_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        lcdfb_pkg::CFG_WIDTH:  width_reg = value[8:0];
        lcdfb_pkg::CFG_HEIGHT: height_reg = value[6:0];
        lcdfb_pkg::CFG_UPSIDE: begin
          if (value[0] != upside) dirty = 1'b1;
          upside = value[0];
        end
        lcdfb_pkg::CFG_INVERT: begin
          if (value[0] != inv) dirty = 1'b1;
          inv = value[0];
        end
        lcdfb_pkg::CFG_CODE0:  code0 = value[7:0];
        lcdfb_pkg::CFG_CODE1:  code1 = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] column_byte(logic [2:0] page, int col);
      logic [7:0] v;
      v = frame[int'(page) * DISP_COLS + col];
      return inv ? (v ^ lcdfb_pkg::BYTE_ONES) : v;
    endfunction

    function void queue_packet(packet_bytes_t bytes, int len, bit which, bit final_pkt);
      int pos;
      int n;
      report_word_t w;
      pos = 0;
      while (pos < len) begin
        n = (len - pos > 8) ? 8 : len - pos;
        w = '0;
        for (int i = 0; i < n; i++) w.data_word[8*i +: 8] = bytes[pos + i];
        pos += n;
        w.valid_bytes  = 4'(n);
        w.which_packet = which;
        w.packet_end   = (pos >= len);
        w.last         = final_pkt && (pos >= len);
        expected_words.push_back(w);
      end
    endfunction

    // Returns 0 for an out-of-range set-pixel item or an undefined operation.
    function bit note_item(lcd_item_t it);
      int x;
      int y;
      int w;
      int h;
      int col_base;
      packet_bytes_t bytes;
      bit useful;
      useful = 1'b1;
      case (it.operation)
        lcdfb_pkg::OP_SET_PIXEL: begin
          w = active_width();
          h = active_height();
          x = it.pixel_x;
          y = it.pixel_y;
          if (x >= w || y >= h) begin
            useful = 1'b0;
          end else begin
            if (upside) begin
              x = w - 1 - x;
              y = h - 1 - y;
            end
            frame[x + (y / 8) * DISP_COLS][y % 8] = it.pixel_white;
            dirty = 1'b1;
          end
        end
        lcdfb_pkg::OP_CLEAR: foreach (frame[i]) frame[i] = '0;
        lcdfb_pkg::OP_REFRESH: begin
          if (dirty || it.force_req) begin
            col_base = 64 * int'(it.chip);
            foreach (bytes[i]) bytes[i] = '0;
            bytes[0]  = code0;
            bytes[1]  = {4'b0000, it.chip, 2'b00};
            bytes[2]  = lcdfb_pkg::CMD_FLAG;
            bytes[5]  = lcdfb_pkg::PAGE_CMD | {5'b00000, it.page};
            bytes[8]  = lcdfb_pkg::COL_CMD;
            bytes[11] = lcdfb_pkg::XFER_LEN;
            for (int i = 0; i < int'(lcdfb_pkg::COLS_PER_PKT); i++) begin
              bytes[int'(lcdfb_pkg::PKT0_COL_FIRST) + i] = column_byte(it.page, col_base + i);
            end
            queue_packet(bytes, int'(lcdfb_pkg::PKT0_LAST_POS) + 1, 1'b0, 1'b0);
            foreach (bytes[i]) bytes[i] = '0;
            bytes[0] = code1;
            bytes[1] = {4'b0000, it.chip, 2'b00} | lcdfb_pkg::DATA_CHIP_FLAG;
            bytes[4] = lcdfb_pkg::XFER_LEN;
            for (int i = 0; i < int'(lcdfb_pkg::COLS_PER_PKT); i++) begin
              bytes[int'(lcdfb_pkg::PKT1_COL_FIRST) + i] =
                column_byte(it.page, col_base + 32 + i);
            end
            queue_packet(bytes, int'(lcdfb_pkg::PKT1_LAST_POS) + 1, 1'b1, 1'b1);
            if (it.chip == lcdfb_pkg::LAST_CHIP && it.page == lcdfb_pkg::LAST_PAGE) begin
              dirty = 1'b0;
            end
          end
        end
        default: useful = 1'b0;
      endcase
      return useful;
    endfunction

    function void note_failure(string msg);
      if (failures < REPORT_LIMIT) $display("%s", msg);
      failures++;
    endfunction

    function void check_word(report_word_t got);
      report_word_t exp;
      if (expected_words.size() == 0) begin
        note_failure($sformatf("Unexpected word: data %h bytes %0d pkt %0b end %0b last %0b",
                               got.data_word, got.valid_bytes, got.which_packet,
                               got.packet_end, got.last));
      end else begin
        exp = expected_words.pop_front();
        if (got.data_word !== exp.data_word || got.valid_bytes !== exp.valid_bytes ||
            got.which_packet !== exp.which_packet || got.packet_end !== exp.packet_end ||
            got.last !== exp.last) begin
          note_failure($sformatf({"Word mismatch: expected data %h bytes %0d pkt %0b end %0b ",
                                  "last %0b, got data %h bytes %0d pkt %0b end %0b last %0b"},
                                 exp.data_word, exp.valid_bytes, exp.which_packet,
                                 exp.packet_end, exp.last, got.data_word, got.valid_bytes,
                                 got.which_packet, got.packet_end, got.last));
        end
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [1:0]                        in_operation;
  logic [7:0]                        in_pixel_x;
  logic [5:0]                        in_pixel_y;
  logic                              in_pixel_white;
  logic [1:0]                        in_chip;
  logic [2:0]                        in_page;
  logic                              in_force_req;
  logic                              out_valid;
  logic                              out_ready;
  logic [63:0]                       out_data_word;
  logic [3:0]                        out_valid_bytes;
  logic                              out_which_packet;
  logic                              out_packet_end;
  logic                              out_last;
  logic                              cfg_we;
  logic [lcdfb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lcdfb_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  framebuffer_tracker sb;
  bit in_burst;
  bit out_burst;

  paged_lcd_framebuffer_packetizer DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lcd_item_t make_item(logic [1:0] op, logic [7:0] x, logic [5:0] y,
                                          logic white, logic [1:0] chip, logic [2:0] page,
                                          logic force_req);
    lcd_item_t it;
    it.operation   = op;
    it.pixel_x     = x;
    it.pixel_y     = y;
    it.pixel_white = white;
    it.chip        = chip;
    it.page        = page;
    it.force_req   = force_req;
    return it;
  endfunction

  function automatic lcd_item_t random_item();
    lcd_item_t it;
    int pick;
    it = make_item(lcdfb_pkg::OP_SET_PIXEL, 8'($urandom), 6'($urandom), 1'($urandom),
                   2'($urandom), 3'($urandom), ($urandom_range(0, 3) == 0));
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      if ($urandom_range(0, 9) != 0) begin
        it.pixel_x = 8'($urandom_range(0, sb.active_width() - 1));
        it.pixel_y = 6'($urandom_range(0, sb.active_height() - 1));
      end
    end else if (pick < 92) begin
      it.operation = lcdfb_pkg::OP_REFRESH;
      if ($urandom_range(0, 4) == 0) begin
        it.chip = lcdfb_pkg::LAST_CHIP;
        it.page = lcdfb_pkg::LAST_PAGE;
      end
    end else if (pick < 95) begin
      it.operation = lcdfb_pkg::OP_CLEAR;
    end else begin
      it.operation = OP_UNDEFINED;
    end
    return it;
  endfunction

  task automatic send_item(input lcd_item_t it, output bit useful);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_operation   = it.operation;
    in_pixel_x     = it.pixel_x;
    in_pixel_y     = it.pixel_y;
    in_pixel_white = it.pixel_white;
    in_chip        = it.chip;
    in_page        = it.page;
    in_force_req   = it.force_req;
    do @(posedge clk); while (!in_ready);
    useful = sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [lcdfb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lcdfb_pkg::CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int w, input int h, input bit up, input bit inv,
                           input int c0, input int c1);
    write_reg(lcdfb_pkg::CFG_WIDTH, 9'(w));
    write_reg(lcdfb_pkg::CFG_HEIGHT, {2'($urandom), 7'(h)});
    write_reg(lcdfb_pkg::CFG_UPSIDE, {8'($urandom), up});
    write_reg(lcdfb_pkg::CFG_INVERT, {8'($urandom), inv});
    write_reg(lcdfb_pkg::CFG_CODE0, {1'($urandom), 8'(c0)});
    write_reg(lcdfb_pkg::CFG_CODE1, {1'($urandom), 8'(c1)});
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    report_word_t got;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.data_word    = out_data_word;
      got.valid_bytes  = out_valid_bytes;
      got.which_packet = out_which_packet;
      got.packet_end   = out_packet_end;
      got.last         = out_last;
      sb.check_word(got);
      @(negedge clk);
    end
  end

  initial begin
    bit useful;
    int counted;
    int sent;
    lcd_item_t directed_items[$];
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = lcdfb_pkg::OP_SET_PIXEL;
    in_pixel_x     = '0;
    in_pixel_y     = '0;
    in_pixel_white = 1'b0;
    in_chip        = '0;
    in_page        = '0;
    in_force_req   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = lcdfb_pkg::CFG_WIDTH;
    cfg_wdata      = '0;
    in_burst       = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // The buffer starts dirty, so the first unforced refresh must report.
    directed_items = '{
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd0,   6'd0,  1'b1, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd255, 6'd63, 1'b1, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd128, 6'd7,  1'b1, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd200, 6'd33, 1'b1, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd200, 6'd33, 1'b0, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd63,  6'd8,  1'b1, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd3, 3'd7, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd2, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd2, 3'd0, 1'b1),
      make_item(OP_UNDEFINED,            8'd255, 6'd63, 1'b1, 2'd3, 3'd7, 1'b1),
      make_item(lcdfb_pkg::OP_CLEAR,     8'd0,   6'd0,  1'b0, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd3, 3'd7, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd3, 3'd7, 1'b1),
      make_item(lcdfb_pkg::OP_SET_PIXEL, 8'd64,  6'd15, 1'b1, 2'd0, 3'd0, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd1, 3'd1, 1'b0),
      make_item(lcdfb_pkg::OP_REFRESH,   8'd0,   6'd0,  1'b0, 2'd3, 3'd7, 1'b0)
    };
    foreach (directed_items[i]) send_item(directed_items[i], useful);
    in_valid = 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(1, 1, 1'b1, 1'b1, 0, 255);
        1: configure(0, 0, 1'b0, 1'b0, 255, 0);
        2: configure(511, 127, 1'b1, 1'b0, $urandom_range(0, 255), $urandom_range(0, 255));
        3: configure($urandom_range(1, 256), $urandom_range(1, 64), 1'($urandom),
                     1'($urandom), $urandom_range(0, 255), $urandom_range(0, 255));
        4: configure(256, 64, 1'b1, 1'b1, $urandom_range(0, 255), $urandom_range(0, 255));
        default: configure(257, 65, 1'b0, 1'b1, $urandom_range(0, 255),
                           $urandom_range(0, 255));
      endcase
      counted = 0;
      sent    = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (sent % 40 == 0) in_burst = ($urandom_range(0, 3) == 0);
        send_item(random_item(), useful);
        counted += useful;
        sent++;
      end
      in_valid = 1'b0;
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/lcdfb_pkg.sv
src/lcdfb_ram.sv
src/paged_lcd_framebuffer_packetizer.sv
tb/sv/tb.sv
